FILE: design/ghp_pkg.sv
// ----------------------------------------------------------------------------
// ghp_pkg
// Shared types and constants of the gzip header parser.
// ----------------------------------------------------------------------------
package ghp_pkg;

  // Width of the byte position counter.
  localparam int OFFSET_BITS = 32;
  // Width used for position sums, wide enough for the offset and the length.
  localparam int SUM_BITS    = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 1;

  // Header constants.
  localparam logic [7:0]  MAGIC1       = 8'h1f;
  localparam logic [7:0]  MAGIC2       = 8'h8b;
  localparam logic [7:0]  METHOD_DEFL  = 8'h08;
  localparam int          FLG_FEXTRA   = 2;
  localparam int          FLG_FNAME    = 3;
  localparam int          FLG_FCOMMENT = 4;
  localparam int          FLG_FHCRC    = 1;
  localparam logic [31:0] MIN_LEN      = 32'd18;
  localparam logic [15:0] FIXED_SKIP   = 16'd6;
  localparam logic [15:0] HCRC_SKIP    = 16'd2;
  localparam int          TRAILER_END  = 9;
  localparam int          TRAILER_NEAR = 10;

  // Parser phase.
  typedef enum logic [3:0] {
    PH_MAGIC1  = 4'd0,
    PH_MAGIC2  = 4'd1,
    PH_METHOD  = 4'd2,
    PH_FLG     = 4'd3,
    PH_FIXED   = 4'd4,
    PH_XLO     = 4'd5,
    PH_XHI     = 4'd6,
    PH_XDATA   = 4'd7,
    PH_NAME    = 4'd8,
    PH_COMMENT = 4'd9,
    PH_HCRC    = 4'd10,
    PH_DONE    = 4'd11
  } phase_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_METHOD  = 3'd3,
    ST_OVERRUN = 3'd4
  } status_t;

  // Input request.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // Result request.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] payload_offset;
    logic [7:0]  header_flags;
  } out_item_t;

  // Result push from the parser into the output buffer.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } push_t;

endpackage

FILE: design/gzip_header_parser.sv
// ----------------------------------------------------------------------------
// gzip_header_parser
// Parses a gzip header one byte per request and reports the payload offset.
// ----------------------------------------------------------------------------
// Pipeline: two register stages; a byte is captured in the input register, then the
// parser writes its result into the output register (or the skid entry behind it).
// Throughput: one byte per cycle; the input stalls only when both result
// entries (output register and skid entry) are full.
// Reset: synchronous, active low; clears the parser, buffer flags and length.
module gzip_header_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ghp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ghp_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data
);

  logic              in_vld_r, in_vld_nxt;
  ghp_pkg::in_item_t in_item_r;
  logic [31:0]       len_r;
  logic              space;
  logic              step;
  logic              accept;
  ghp_pkg::push_t    push;

  assign step     = in_vld_r && space;
  assign in_stall = in_vld_r && !space;
  assign accept   = in_valid && !in_stall;

  // Input register occupancy.
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (step) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      len_r    <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r <= in_data;
    end
  end

  ghp_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .item          (in_item_r),
    .stream_length (len_r),
    .push          (push)
  );

  ghp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: design/ghp_parser.sv
// ----------------------------------------------------------------------------
// ghp_parser
// Per-byte header state machine; produces at most one result per file.
// ----------------------------------------------------------------------------
module ghp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  ghp_pkg::in_item_t item,
  input  logic [31:0]       stream_length,
  output ghp_pkg::push_t    push
);

  ghp_pkg::phase_t                  phase_r, phase_nxt;
  logic [ghp_pkg::OFFSET_BITS-1:0]  idx_r, idx_nxt;
  logic [15:0]                      skip_r, skip_nxt;
  logic [7:0]                       xlo_r, xlo_nxt;
  logic [7:0]                       flg_r, flg_nxt;
  logic                             given_r, given_nxt;

  logic [ghp_pkg::SUM_BITS-1:0]     idx_ext, len_ext, off_sum;
  logic                             err, emit, near_end, fits;
  ghp_pkg::status_t                 status;
  ghp_pkg::phase_t                  ph;
  logic [15:0]                      skip_dec;

  // Next optional section after the given one, from the latched flags.
  function automatic ghp_pkg::phase_t next_section(ghp_pkg::phase_t after,
                                                   logic [7:0] flg);
    ghp_pkg::phase_t res;
    if (after < ghp_pkg::PH_XLO && flg[ghp_pkg::FLG_FEXTRA]) begin
      res = ghp_pkg::PH_XLO;
    end else if (after < ghp_pkg::PH_NAME && flg[ghp_pkg::FLG_FNAME]) begin
      res = ghp_pkg::PH_NAME;
    end else if (after < ghp_pkg::PH_COMMENT && flg[ghp_pkg::FLG_FCOMMENT]) begin
      res = ghp_pkg::PH_COMMENT;
    end else if (after < ghp_pkg::PH_HCRC && flg[ghp_pkg::FLG_FHCRC]) begin
      res = ghp_pkg::PH_HCRC;
    end else begin
      res = ghp_pkg::PH_DONE;
    end
    return res;
  endfunction

  // Position arithmetic against the configured length.
  assign idx_ext  = ghp_pkg::SUM_BITS'(idx_r);
  assign len_ext  = ghp_pkg::SUM_BITS'(stream_length);
  assign off_sum  = idx_ext + ghp_pkg::SUM_BITS'(1);
  assign fits     = (idx_ext + ghp_pkg::SUM_BITS'(ghp_pkg::TRAILER_END)) < len_ext;
  assign near_end = (idx_ext + ghp_pkg::SUM_BITS'(ghp_pkg::TRAILER_NEAR)) >= len_ext;
  assign skip_dec = skip_r - 16'd1;

  // Next state and result for the byte being stepped.
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    skip_nxt  = skip_r;
    xlo_nxt   = xlo_r;
    flg_nxt   = flg_r;
    given_nxt = given_r;
    err       = 1'b0;
    emit      = 1'b0;
    status    = ghp_pkg::ST_OK;
    ph        = phase_r;
    push      = '0;

    if (step) begin
      if (!given_r && phase_r < ghp_pkg::PH_DONE) begin
        unique case (phase_r)
          ghp_pkg::PH_MAGIC1: begin
            if (stream_length < ghp_pkg::MIN_LEN) begin
              status = ghp_pkg::ST_SHORT;
              err    = 1'b1;
            end else if (item.data_byte != ghp_pkg::MAGIC1) begin
              status = ghp_pkg::ST_MAGIC;
              err    = 1'b1;
            end else begin
              ph = ghp_pkg::PH_MAGIC2;
            end
          end
          ghp_pkg::PH_MAGIC2: begin
            if (item.data_byte != ghp_pkg::MAGIC2) begin
              status = ghp_pkg::ST_MAGIC;
              err    = 1'b1;
            end else begin
              ph = ghp_pkg::PH_METHOD;
            end
          end
          ghp_pkg::PH_METHOD: begin
            if (item.data_byte != ghp_pkg::METHOD_DEFL) begin
              status = ghp_pkg::ST_METHOD;
              err    = 1'b1;
            end else begin
              ph = ghp_pkg::PH_FLG;
            end
          end
          ghp_pkg::PH_FLG: begin
            flg_nxt  = item.data_byte;
            skip_nxt = ghp_pkg::FIXED_SKIP;
            ph       = ghp_pkg::PH_FIXED;
          end
          ghp_pkg::PH_FIXED, ghp_pkg::PH_XDATA, ghp_pkg::PH_HCRC: begin
            skip_nxt = skip_dec;
            if (skip_dec == 16'd0) begin
              ph = next_section(phase_r, flg_r);
            end
          end
          ghp_pkg::PH_XLO: begin
            xlo_nxt = item.data_byte;
            ph      = ghp_pkg::PH_XHI;
          end
          ghp_pkg::PH_XHI: begin
            skip_nxt = {item.data_byte, xlo_r};
            if ({item.data_byte, xlo_r} == 16'd0) begin
              ph = next_section(ghp_pkg::PH_XDATA, flg_r);
            end else begin
              ph = ghp_pkg::PH_XDATA;
            end
          end
          ghp_pkg::PH_NAME, ghp_pkg::PH_COMMENT: begin
            if (item.data_byte == 8'd0) begin
              ph = next_section(phase_r, flg_r);
            end
          end
          default: begin
          end
        endcase

        // Entering the header CRC always starts a two-byte skip.
        if (ph == ghp_pkg::PH_HCRC && phase_r != ghp_pkg::PH_HCRC) begin
          skip_nxt = ghp_pkg::HCRC_SKIP;
        end
        phase_nxt = ph;

        if (err) begin
          emit = 1'b1;
        end else if (ph == ghp_pkg::PH_DONE) begin
          emit = 1'b1;
          if (!fits) begin
            status = ghp_pkg::ST_OVERRUN;
          end
        end else if (near_end) begin
          emit   = 1'b1;
          status = ghp_pkg::ST_OVERRUN;
        end
      end

      // A file that ends without a result reports an overrun.
      if (!emit && !given_r && item.last_byte) begin
        emit   = 1'b1;
        status = ghp_pkg::ST_OVERRUN;
      end

      if (emit) begin
        push.valid               = 1'b1;
        push.item.status         = status;
        push.item.payload_offset = (status == ghp_pkg::ST_OK) ? off_sum[31:0] : 32'd0;
        push.item.header_flags   = flg_nxt;
        given_nxt                = 1'b1;
        phase_nxt                = ghp_pkg::PH_DONE;
      end

      // The last byte rearms the parser for the next file.
      if (item.last_byte) begin
        phase_nxt = ghp_pkg::PH_MAGIC1;
        idx_nxt   = '0;
        skip_nxt  = '0;
        xlo_nxt   = '0;
        flg_nxt   = '0;
        given_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + ghp_pkg::OFFSET_BITS'(1);
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ghp_pkg::PH_MAGIC1;
      idx_r   <= '0;
      skip_r  <= '0;
      xlo_r   <= '0;
      flg_r   <= '0;
      given_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      skip_r  <= skip_nxt;
      xlo_r   <= xlo_nxt;
      flg_r   <= flg_nxt;
      given_r <= given_nxt;
    end
  end

  // A file gives at most one result before it is rearmed.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !given_r)
    else $error("second result within one file");

  // Error results never carry an offset.
  a_err_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid && push.item.status != ghp_pkg::ST_OK) |-> push.item.payload_offset == 32'd0)
    else $error("error result carries an offset");

  // After a result that is not on the last byte, the parser sits in its done phase.
  a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid && !item.last_byte) |=> (phase_r == ghp_pkg::PH_DONE && given_r))
    else $error("parser not parked after result");

endmodule

FILE: design/ghp_out_buf.sv
// ----------------------------------------------------------------------------
// ghp_out_buf
// Two-entry result buffer: an output register backed by one skid entry.
// ----------------------------------------------------------------------------
module ghp_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  ghp_pkg::push_t     push,
  output logic               space,
  output logic               out_valid,
  input  logic               out_stall,
  output ghp_pkg::out_item_t out_data
);

  logic               ov_r, ov_nxt;
  logic               sv_r, sv_nxt;
  ghp_pkg::out_item_t out_r, out_nxt;
  ghp_pkg::out_item_t skid_r, skid_nxt;
  logic               pop;

  assign pop       = ov_r && !out_stall;
  assign space     = !sv_r;
  assign out_valid = ov_r;
  assign out_data  = out_r;

  // Buffer control.
  always_comb begin
    ov_nxt   = ov_r;
    sv_nxt   = sv_r;
    out_nxt  = out_r;
    skid_nxt = skid_r;
    if (sv_r) begin
      if (pop) begin
        out_nxt = skid_r;
        sv_nxt  = 1'b0;
      end
    end else if (push.valid) begin
      if (ov_r && !pop) begin
        skid_nxt = push.item;
        sv_nxt   = 1'b1;
      end else begin
        out_nxt = push.item;
        ov_nxt  = 1'b1;
      end
    end else if (pop) begin
      ov_nxt = 1'b0;
    end
  end

  // Control flags reset; payload does not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      sv_r <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  // The skid entry is only used behind a full output register.
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> ov_r)
    else $error("skid entry valid with empty output register");

  // The parser never pushes into a full buffer.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !sv_r)
    else $error("result pushed into full buffer");

  // A result arriving behind a stalled output lands in the skid entry.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid && ov_r && out_stall) |=> sv_r)
    else $error("result lost behind stalled output");

endmodule
